### rtl/lzfd_pkg.sv
// ----------------------------------------------------------------------------
// lzfd_pkg: shared definitions for the flag-bit LZ decompressor
// Widths, history geometry, parser phase codes and the parser state record.
// ----------------------------------------------------------------------------
package lzfd_pkg;

  localparam int HIST_DEPTH = 8192;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = HIST_AW + 1;
  localparam int LANES      = 4;
  localparam int LANE_IW    = $clog2(LANES);
  localparam int LANE_CW    = LANE_IW + 1;
  localparam int LEN_W      = 9;
  localparam int SHORT_WIN  = 256;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_CODE,
    PH_LIT,
    PH_WHI,
    PH_WLO,
    PH_WLEN,
    PH_SOFF
  } phase_t;

  // Progress through the code bits of an item that is not yet resolved.
  typedef enum logic [1:0] {
    CS_START,
    CS_ZERO,
    CS_LEN_HI,
    CS_LEN_LO
  } code_t;

  typedef struct packed {
    phase_t            phase;
    code_t             code;
    logic [LEN_W-1:0]  len;
    byte_t             flag;
    logic [3:0]        bits;
  } parse_t;

  localparam parse_t PARSE_RST = '{
    phase: PH_CODE,
    code:  CS_START,
    len:   '0,
    flag:  '0,
    bits:  '0
  };

endpackage

### rtl/lzfd_stream_if.sv
// ----------------------------------------------------------------------------
// lzfd_stream_if: valid/ready channels of the flag-bit LZ decompressor
// One interface for compressed input beats and one for decoded result beats.
// ----------------------------------------------------------------------------
interface lzfd_in_if import lzfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzfd_out_if import lzfd_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_t      out_byte0;
  byte_t      out_byte1;
  byte_t      out_byte2;
  byte_t      out_byte3;
  logic [2:0] out_count;
  logic       run_last;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output out_count, output run_last, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                  input out_byte3, input out_count, input run_last, output ready);
endinterface

### rtl/lz_flagbit_decompressor.sv
// ----------------------------------------------------------------------------
// lz_flagbit_decompressor: streaming flag-bit LZ decoder, 8 KiB window
// Parses flag, literal, match word, length and offset bytes and replays matches
// from an on-chip history memory, packing up to four bytes per result.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  in_ch     in    in_byte, end_of_stream
//  out_ch    out   out_byte0..out_byte3, out_count, run_last
//
//  Flag and header bytes that start no copy leave the input ready for the next
//  byte; a literal holds it until its byte has left the packing buffer. A match
//  holds the input until its replay is done: one history read a cycle while the
//  output is free, a registered read port, and a gap when the packing buffer fills.
//  Reset is synchronous and leaves the history memory uncleared; unwritten
//  entries are never used. A stalled output holds the replay.
// ----------------------------------------------------------------------------
module lz_flagbit_decompressor import lzfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lzfd_in_if.sink    in_ch,
  lzfd_out_if.source out_ch
);

  // Walks the pending code bits until the item type is known or bits run out.
  function automatic parse_t resolve(parse_t s);
    parse_t r;
    logic   b;
    r = s;
    b = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (r.phase == PH_CODE && r.bits != 4'd0) begin
        b      = r.flag[7];
        r.flag = {r.flag[6:0], 1'b0};
        r.bits = r.bits - 4'd1;
        case (r.code)
          CS_START: begin
            if (b) r.phase = PH_LIT;
            else   r.code  = CS_ZERO;
          end
          CS_ZERO: begin
            if (b) begin
              r.phase = PH_WHI;
              r.code  = CS_START;
            end else begin
              r.code = CS_LEN_HI;
              r.len  = '0;
            end
          end
          CS_LEN_HI: begin
            r.len  = LEN_W'(b);
            r.code = CS_LEN_LO;
          end
          CS_LEN_LO: begin
            r.len   = LEN_W'({r.len[0], b}) + LEN_W'(2);
            r.code  = CS_START;
            r.phase = PH_SOFF;
          end
          default: r.code = CS_START;
        endcase
      end
    end
    return r;
  endfunction

  byte_t hist_mem [HIST_DEPTH];

  parse_t             st_r, st_nxt;
  byte_t              word_hi_r, word_hi_nxt;
  logic [CNT_W-1:0]   dist_r, dist_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]   pc_r, pc_nxt;
  logic               eos_pend_r, eos_pend_nxt;
  logic               busy_r, busy_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [HIST_AW-1:0] src_r, src_nxt;
  logic [CNT_W-1:0]   rd_pc_r, rd_pc_nxt;
  logic               first_r, first_nxt;
  logic               inflight_r, inflight_nxt;
  logic               zero_r, zero_nxt;
  logic               fwd_r, fwd_nxt;
  byte_t              rdata_r;
  byte_t              last_byte_r, last_byte_nxt;
  byte_t              acc_bytes_r [LANES];
  byte_t              acc_bytes_nxt [LANES];
  logic [LANE_CW-1:0] acc_cnt_r, acc_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  byte_t              out_bytes_r [LANES];
  byte_t              out_bytes_nxt [LANES];
  logic [LANE_CW-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  parse_t             s1, s2;
  logic               in_ready, accept, out_free, copy_tail, flush, issue;
  logic               start_copy;
  logic [LANE_CW-1:0] acc_base;
  logic [15:0]        word;
  logic [CNT_W-1:0]   new_dist;
  logic [LEN_W-1:0]   new_len;
  byte_t              arr_val;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_wa;
  byte_t              mem_wd;

  assign arr_val = zero_r ? '0 : (fwd_r ? last_byte_r : rdata_r);

  always_comb begin
    st_nxt        = st_r;
    word_hi_nxt   = word_hi_r;
    dist_nxt      = dist_r;
    wp_nxt        = wp_r;
    pc_nxt        = pc_r;
    eos_pend_nxt  = eos_pend_r;
    busy_nxt      = busy_r;
    remain_nxt    = remain_r;
    src_nxt       = src_r;
    rd_pc_nxt     = rd_pc_r;
    first_nxt     = first_r;
    inflight_nxt  = 1'b0;
    zero_nxt      = zero_r;
    fwd_nxt       = fwd_r;
    last_byte_nxt = last_byte_r;
    acc_bytes_nxt = acc_bytes_r;
    out_valid_nxt = out_valid_r;
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = wp_r;
    mem_wd        = arr_val;
    start_copy    = 1'b0;
    word          = '0;
    new_dist      = dist_r;
    new_len       = '0;
    s1            = resolve(st_r);
    s2            = s1;

    in_ready  = !busy_r && (acc_cnt_r == '0);
    accept    = in_ch.valid && in_ready;
    out_free  = !out_valid_r || out_ch.ready;
    copy_tail = (remain_r == '0) && !inflight_r;
    flush     = (acc_cnt_r != '0) && ((acc_cnt_r == LANE_CW'(LANES)) || copy_tail) && out_free;

    // Output register: drains on ready, refills from the packing buffer.
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (flush) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = acc_cnt_r;
      out_last_nxt  = copy_tail;
      for (int k = 0; k < LANES; k++) begin
        out_bytes_nxt[k] = (LANE_CW'(k) < acc_cnt_r) ? acc_bytes_r[k] : '0;
      end
    end

    // A history byte returning from the read port lands in the next lane.
    acc_base = flush ? '0 : acc_cnt_r;
    if (inflight_r) begin
      acc_bytes_nxt[acc_base[LANE_IW-1:0]] = arr_val;
      acc_cnt_nxt   = acc_base + LANE_CW'(1);
      mem_we        = 1'b1;
      mem_wa        = wp_r;
      mem_wd        = arr_val;
      last_byte_nxt = arr_val;
      wp_nxt        = wp_r + HIST_AW'(1);
      pc_nxt        = (pc_r == CNT_W'(HIST_DEPTH)) ? pc_r : pc_r + CNT_W'(1);
    end else begin
      acc_cnt_nxt = acc_base;
    end

    // Issue a history read only when its byte is sure to find a free lane.
    issue = busy_r && (remain_r != '0) && (acc_cnt_nxt < LANE_CW'(LANES));
    if (issue) begin
      inflight_nxt = 1'b1;
      zero_nxt     = rd_pc_r < dist_r;
      // At distance one the source is the byte written in the same cycle.
      fwd_nxt      = (dist_r == CNT_W'(1)) && !first_r;
      src_nxt      = src_r + HIST_AW'(1);
      rd_pc_nxt    = (rd_pc_r == CNT_W'(HIST_DEPTH)) ? rd_pc_r : rd_pc_r + CNT_W'(1);
      remain_nxt   = remain_r - LEN_W'(1);
      first_nxt    = 1'b0;
    end

    if (busy_r && copy_tail) begin
      busy_nxt = 1'b0;
      if (eos_pend_r) begin
        st_nxt       = PARSE_RST;
        wp_nxt       = '0;
        pc_nxt       = '0;
        dist_nxt     = '0;
        eos_pend_nxt = 1'b0;
      end
    end

    if (accept) begin
      st_nxt = s1;
      case (s1.phase)
        PH_CODE: begin
          s2.flag = in_ch.in_byte;
          s2.bits = 4'd8;
          st_nxt  = resolve(s2);
        end
        PH_LIT: begin
          mem_we           = 1'b1;
          mem_wa           = wp_r;
          mem_wd           = in_ch.in_byte;
          last_byte_nxt    = in_ch.in_byte;
          wp_nxt           = wp_r + HIST_AW'(1);
          pc_nxt           = (pc_r == CNT_W'(HIST_DEPTH)) ? pc_r : pc_r + CNT_W'(1);
          acc_bytes_nxt[0] = in_ch.in_byte;
          acc_cnt_nxt      = LANE_CW'(1);
          st_nxt.phase     = PH_CODE;
          st_nxt.code      = CS_START;
        end
        PH_WHI: begin
          word_hi_nxt  = in_ch.in_byte;
          st_nxt.phase = PH_WLO;
        end
        PH_WLO: begin
          word     = {word_hi_r, in_ch.in_byte};
          new_dist = CNT_W'(HIST_DEPTH) - CNT_W'(word[15:3]);
          dist_nxt = new_dist;
          if (word[2:0] != 3'd0) begin
            new_len    = LEN_W'(word[2:0]) + LEN_W'(2);
            start_copy = 1'b1;
          end else begin
            st_nxt.phase = PH_WLEN;
          end
        end
        PH_WLEN: begin
          new_len    = LEN_W'(in_ch.in_byte) + LEN_W'(1);
          start_copy = 1'b1;
        end
        PH_SOFF: begin
          new_dist   = CNT_W'(SHORT_WIN) - CNT_W'(in_ch.in_byte);
          dist_nxt   = new_dist;
          new_len    = s1.len;
          start_copy = 1'b1;
        end
        default: begin
          st_nxt.phase = PH_CODE;
          st_nxt.code  = CS_START;
        end
      endcase

      if (start_copy) begin
        st_nxt.phase = PH_CODE;
        st_nxt.code  = CS_START;
        st_nxt.len   = '0;
        busy_nxt     = 1'b1;
        remain_nxt   = new_len;
        src_nxt      = wp_r - new_dist[HIST_AW-1:0];
        rd_pc_nxt    = pc_r;
        first_nxt    = 1'b1;
        eos_pend_nxt = in_ch.end_of_stream;
      end else if (in_ch.end_of_stream) begin
        st_nxt   = PARSE_RST;
        wp_nxt   = '0;
        pc_nxt   = '0;
        dist_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= PARSE_RST;
      dist_r      <= '0;
      wp_r        <= '0;
      pc_r        <= '0;
      eos_pend_r  <= 1'b0;
      busy_r      <= 1'b0;
      remain_r    <= '0;
      inflight_r  <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dist_r      <= dist_nxt;
      wp_r        <= wp_nxt;
      pc_r        <= pc_nxt;
      eos_pend_r  <= eos_pend_nxt;
      busy_r      <= busy_nxt;
      remain_r    <= remain_nxt;
      inflight_r  <= inflight_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_hi_r   <= word_hi_nxt;
    src_r       <= src_nxt;
    rd_pc_r     <= rd_pc_nxt;
    first_r     <= first_nxt;
    zero_r      <= zero_nxt;
    fwd_r       <= fwd_nxt;
    last_byte_r <= last_byte_nxt;
    acc_bytes_r <= acc_bytes_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_wa] <= mem_wd;
    if (issue)  rdata_r <= hist_mem[src_r];
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte0 = out_bytes_r[0];
  assign out_ch.out_byte1 = out_bytes_r[1];
  assign out_ch.out_byte2 = out_bytes_r[2];
  assign out_ch.out_byte3 = out_bytes_r[3];
  assign out_ch.out_count = out_count_r;
  assign out_ch.run_last  = out_last_r;

endmodule
